// ===== rtl/core/bpp_pkg.sv =====
// ----------------------------------------------------------------------------
// bpp_pkg
// Shared types, constants and helpers of the black pixel projection profile.
// ----------------------------------------------------------------------------
package bpp_pkg;

  localparam int unsigned COORD_W           = 12;
  localparam int unsigned COUNT_W           = 13;
  localparam int unsigned PIXEL_W           = 8;
  localparam int unsigned CFG_IDX_W         = 2;
  localparam int unsigned MAX_REGION_WIDTH  = 4096;
  localparam int unsigned MAX_REGION_HEIGHT = 4096;

  localparam logic [COUNT_W-1:0] COUNT_MAX         = 13'd8191;
  localparam logic [COORD_W-1:0] IMAGE_LAST_COLUMN = 12'd4095;
  localparam logic [COUNT_W-1:0] REGION_DIM_RESET  = 13'd4096;

  typedef enum logic {
    OP_PIXEL   = 1'b0,
    OP_READOUT = 1'b1
  } opcode_e;

  typedef enum logic {
    KIND_ROW    = 1'b0,
    KIND_COLUMN = 1'b1
  } profile_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT   = 2'd0,
    REG_TOP    = 2'd1,
    REG_WIDTH  = 2'd2,
    REG_HEIGHT = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    profile_kind_e       profile_kind;
    logic [COORD_W-1:0]  profile_index;
    logic [COUNT_W-1:0]  black_count;
  } result_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    return (v == COUNT_MAX) ? v : v + COUNT_W'(1);
  endfunction

endpackage

// ===== rtl/core/bpp_if.sv =====
// ----------------------------------------------------------------------------
// bpp channel interfaces
// Valid/ready channels for pixels in, profile counts out and register writes.
// ----------------------------------------------------------------------------
interface bpp_pix_if import bpp_pkg::*; ();
  logic               valid;
  logic               ready;
  opcode_e            opcode;
  logic [PIXEL_W-1:0] pixel_value;
  logic [COORD_W-1:0] pixel_column;
  logic [COORD_W-1:0] pixel_row;

  modport source (
    output valid, opcode, pixel_value, pixel_column, pixel_row,
    input  ready
  );
  modport sink (
    input  valid, opcode, pixel_value, pixel_column, pixel_row,
    output ready
  );
endinterface

interface bpp_res_if import bpp_pkg::*; ();
  logic               valid;
  logic               ready;
  profile_kind_e      profile_kind;
  logic [COORD_W-1:0] profile_index;
  logic [COUNT_W-1:0] black_count;

  modport source (
    output valid, profile_kind, profile_index, black_count,
    input  ready
  );
  modport sink (
    input  valid, profile_kind, profile_index, black_count,
    output ready
  );
endinterface

interface bpp_cfg_if import bpp_pkg::*; ();
  logic               valid;
  logic               ready;
  cfg_reg_e           index;
  logic [COUNT_W-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// ===== rtl/core/black_pixel_projection_profile_unit.sv =====
// ----------------------------------------------------------------------------
// black_pixel_projection_profile_unit
// Row and column black pixel counts over a rectangular region of a raster
// stream of binarized pixels; column counts live in a one-read, one-write RAM.
//
//   channel  dir  transaction
//   pix_i    in   pixel item (opcode 0) or column readout-and-clear (opcode 1)
//   res_o    out  row total (kind 0) or column total (kind 1)
//   cfg_i    in   register write: left, top, width, height
//
// One item per cycle while pix_i.ready is high; each result passes stage 1
// and the result FIFO. Read-modify-write of the column RAM: read at accept,
// update in the next cycle, with the previous cycle's write forwarded.
// After reset a clearing pass zeroes every RAM entry, with pix_i.ready low;
// cfg_i is always ready.
// Results queue in a 4-entry FIFO; pix_i.ready drops when it could overflow.
// ----------------------------------------------------------------------------
module black_pixel_projection_profile_unit import bpp_pkg::*; #(
  parameter int unsigned MaxRegionWidth = MAX_REGION_WIDTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bpp_pix_if.sink    pix_i,
  bpp_res_if.source  res_o,
  bpp_cfg_if.sink    cfg_i
);

  localparam int unsigned AW        = (MaxRegionWidth > 1) ? $clog2(MaxRegionWidth) : 1;
  localparam int unsigned IdxW      = (AW > COORD_W) ? AW : COORD_W;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAW    = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  typedef struct packed {
    logic    has_res;
    logic    use_mem;   // result count comes from the RAM entry
    logic    do_inc;
    logic    do_clr;
    result_t res;
  } s1_t;

  // configuration
  logic [COORD_W-1:0] left_q, top_q;
  logic [COUNT_W-1:0] width_q, height_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      top_q    <= '0;
      width_q  <= REGION_DIM_RESET;
      height_q <= REGION_DIM_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_LEFT:   left_q   <= cfg_i.data[COORD_W-1:0];
        REG_TOP:    top_q    <= cfg_i.data[COORD_W-1:0];
        REG_WIDTH:  width_q  <= cfg_i.data;
        REG_HEIGHT: height_q <= cfg_i.data;
        default:    ;
      endcase
    end
  end

  // clearing pass
  logic          clr_active_q;
  logic [AW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_cnt_q    <= '0;
    end else if (clr_active_q) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
      if (clr_cnt_q == AW'(MaxRegionWidth - 1)) begin
        clr_active_q <= 1'b0;
      end
    end
  end

  // stage 0: region decode
  logic               s1_valid_q;
  s1_t                s1_q;
  logic [FifoCntW-1:0] fifo_cnt_q;
  logic               pix_acc;
  logic [COUNT_W-1:0] w_eff, h_eff;
  logic [COORD_W-1:0] rc, rr;
  logic [13:0]        last_sum;
  logic [COORD_W-1:0] last_col;
  logic               in_region, is_last, is_black, rd_in_range;
  logic [IdxW-1:0]    addr_ext;
  logic [AW-1:0]      rd_addr;
  logic [COUNT_W-1:0] row_cnt_q, row_cnt_inc;
  s1_t                s1_d;

  assign pix_i.ready = !clr_active_q &&
                       ((fifo_cnt_q + FifoCntW'(s1_valid_q)) <= FifoCntW'(FifoDepth - 1));
  assign pix_acc = pix_i.valid && pix_i.ready;

  always_comb begin
    w_eff = (32'(width_q) > 32'(MaxRegionWidth)) ? COUNT_W'(MaxRegionWidth) : width_q;
    h_eff = (32'(height_q) > 32'(MAX_REGION_HEIGHT)) ? COUNT_W'(MAX_REGION_HEIGHT)
                                                      : height_q;
    rc = pix_i.pixel_column - left_q;
    rr = pix_i.pixel_row - top_q;
    in_region = (w_eff != '0) && (h_eff != '0) &&
                (pix_i.pixel_column >= left_q) && (pix_i.pixel_row >= top_q) &&
                ({1'b0, rc} < w_eff) && ({1'b0, rr} < h_eff);
    last_sum = 14'(left_q) + 14'(w_eff) - 14'd1;
    last_col = (last_sum > 14'(IMAGE_LAST_COLUMN)) ? IMAGE_LAST_COLUMN
                                                   : last_sum[COORD_W-1:0];
    is_last  = (pix_i.pixel_column == last_col);
    is_black = (pix_i.pixel_value == '0);
    rd_in_range = 32'(pix_i.pixel_column) < 32'(MaxRegionWidth);
    addr_ext = (pix_i.opcode == OP_READOUT) ? IdxW'(pix_i.pixel_column) : IdxW'(rc);
    rd_addr  = addr_ext[AW-1:0];
    row_cnt_inc = is_black ? sat_inc(row_cnt_q) : row_cnt_q;

    s1_d = '0;
    if (pix_i.opcode == OP_READOUT) begin
      s1_d.has_res           = 1'b1;
      s1_d.use_mem           = rd_in_range;
      s1_d.do_clr            = rd_in_range;
      s1_d.res.profile_kind  = KIND_COLUMN;
      s1_d.res.profile_index = pix_i.pixel_column;
    end else begin
      s1_d.has_res           = in_region && is_last;
      s1_d.do_inc            = in_region && is_black;
      s1_d.res.profile_kind  = KIND_ROW;
      s1_d.res.profile_index = rr;
      s1_d.res.black_count   = row_cnt_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q <= '0;
    end else if (pix_acc && (pix_i.opcode == OP_PIXEL) && in_region) begin
      row_cnt_q <= is_last ? '0 : row_cnt_inc;
    end
  end

  logic [AW-1:0] s1_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= pix_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q      <= s1_d;
    s1_addr_q <= rd_addr;
  end

  // column count RAM
  logic [COUNT_W-1:0] mem_q [MaxRegionWidth];
  logic [COUNT_W-1:0] rd_data_q;
  logic               mem_we;
  logic [AW-1:0]      wr_addr;
  logic [COUNT_W-1:0] wr_data;

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  // stage 1: modify and write back
  logic               fwd_vld_q;
  logic [AW-1:0]      fwd_addr_q;
  logic [COUNT_W-1:0] fwd_data_q;
  logic [COUNT_W-1:0] cur_cnt;
  result_t            s1_res;

  always_comb begin
    // entry written in the cycle this item read it: take the newer value
    cur_cnt = (fwd_vld_q && (fwd_addr_q == s1_addr_q)) ? fwd_data_q : rd_data_q;
    mem_we  = 1'b0;
    wr_addr = s1_addr_q;
    wr_data = '0;
    if (clr_active_q) begin
      mem_we  = 1'b1;
      wr_addr = clr_cnt_q;
    end else if (s1_valid_q && s1_q.do_inc) begin
      mem_we  = 1'b1;
      wr_data = sat_inc(cur_cnt);
    end else if (s1_valid_q && s1_q.do_clr) begin
      mem_we  = 1'b1;
    end
    s1_res = s1_q.res;
    if (s1_q.use_mem) begin
      s1_res.black_count = cur_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_vld_q <= 1'b0;
    end else begin
      fwd_vld_q <= mem_we;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_addr_q <= wr_addr;
    fwd_data_q <= wr_data;
  end

  // result FIFO
  result_t           fifo_q [FifoDepth];
  logic [FifoAW-1:0] fifo_wr_q, fifo_rd_q;
  logic              push, pop;
  result_t           head;

  assign push = s1_valid_q && s1_q.has_res;
  assign pop  = res_o.valid && res_o.ready;
  assign head = fifo_q[fifo_rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fifo_wr_q  <= '0;
      fifo_rd_q  <= '0;
      fifo_cnt_q <= '0;
    end else begin
      if (push) begin
        fifo_wr_q <= fifo_wr_q + FifoAW'(1);
      end
      if (pop) begin
        fifo_rd_q <= fifo_rd_q + FifoAW'(1);
      end
      fifo_cnt_q <= fifo_cnt_q + FifoCntW'(push) - FifoCntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[fifo_wr_q] <= s1_res;
    end
  end

  assign res_o.valid         = (fifo_cnt_q != '0);
  assign res_o.profile_kind  = head.profile_kind;
  assign res_o.profile_index = head.profile_index;
  assign res_o.black_count   = head.black_count;

`ifndef SYNTHESIS
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_active_q |-> !pix_i.ready)
    else $error("pixel transaction accepted during clearing pass");

  a_no_update_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_active_q |-> !s1_valid_q)
    else $error("RAM update collides with clearing pass");

  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_cnt_q <= FifoCntW'(FifoDepth))
    else $error("result FIFO overflow");

  a_row_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_acc && (pix_i.opcode == OP_PIXEL) && in_region && is_last)
      |=> (row_cnt_q == '0))
    else $error("row count not restarted after row total");
`endif

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the black pixel projection profile unit. Raster
// rows of random pixels over random regions, stray pixels and column
// readouts go in; a model of the row total and column store predicts every
// profile count, which is compared field by field as it comes out.
// ----------------------------------------------------------------------------
module tb_top;
  import bpp_pkg::*;

  class profile_scoreboard;
    logic [COORD_W-1:0] left_q;
    logic [COORD_W-1:0] top_q;
    logic [COUNT_W-1:0] width_q;
    logic [COUNT_W-1:0] height_q;
    logic [COUNT_W-1:0] column_totals [MAX_REGION_WIDTH];
    logic [COUNT_W-1:0] row_total;
    result_t            expected_counts [$];
    int unsigned        mismatches;

    function new();
      left_q     = '0;
      top_q      = '0;
      width_q    = REGION_DIM_RESET;
      height_q   = REGION_DIM_RESET;
      row_total  = '0;
      mismatches = 0;
      foreach (column_totals[i]) column_totals[i] = '0;
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 200) $display("%0t: mismatch: %s", $time, msg);
    endtask

    function logic [COUNT_W-1:0] bump(logic [COUNT_W-1:0] v);
      return v + COUNT_W'(v != COUNT_MAX);
    endfunction

    function void set_register(cfg_reg_e idx, logic [COUNT_W-1:0] data);
      case (idx)
        REG_LEFT:   left_q   = data[COORD_W-1:0];
        REG_TOP:    top_q    = data[COORD_W-1:0];
        REG_WIDTH:  width_q  = data;
        REG_HEIGHT: height_q = data;
        default: ;
      endcase
    endfunction

    // Called once per accepted pixel transaction.
    function void predict_profile(opcode_e op, logic [PIXEL_W-1:0] value,
                                  logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
      int unsigned w, h, rc, rr, last;
      result_t     r;
      if (op == OP_READOUT) begin
        r.profile_kind  = KIND_COLUMN;
        r.profile_index = col;
        r.black_count   = column_totals[col];
        column_totals[col] = '0;
        expected_counts.push_back(r);
        return;
      end
      w = (width_q > MAX_REGION_WIDTH) ? MAX_REGION_WIDTH : width_q;
      h = (height_q > MAX_REGION_HEIGHT) ? MAX_REGION_HEIGHT : height_q;
      if (w == 0 || h == 0) return;
      if (col < left_q || row < top_q) return;
      rc = col - left_q;
      rr = row - top_q;
      if (rc >= w || rr >= h) return;
      if (value == '0) begin
        row_total         = bump(row_total);
        column_totals[rc] = bump(column_totals[rc]);
      end
      // a region running off the image closes its rows at the last column
      last = left_q + w - 1;
      if (last > IMAGE_LAST_COLUMN) last = IMAGE_LAST_COLUMN;
      if (col == last) begin
        r.profile_kind  = KIND_ROW;
        r.profile_index = COORD_W'(rr);
        r.black_count   = row_total;
        row_total       = '0;
        expected_counts.push_back(r);
      end
    endfunction

    task compare_count(result_t got);
      result_t want;
      if (expected_counts.size() == 0) begin
        report($sformatf("unexpected result kind=%0d index=%0d count=%0d",
                         got.profile_kind, got.profile_index, got.black_count));
        return;
      end
      want = expected_counts.pop_front();
      if (got.profile_kind !== want.profile_kind)
        report($sformatf("kind %0d, want %0d", got.profile_kind, want.profile_kind));
      if (got.profile_index !== want.profile_index)
        report($sformatf("index %0d, want %0d", got.profile_index, want.profile_index));
      if (got.black_count !== want.black_count)
        report($sformatf("count %0d, want %0d (kind %0d index %0d)", got.black_count,
                         want.black_count, want.profile_kind, want.profile_index));
    endtask

    function int unsigned outstanding();
      return expected_counts.size();
    endfunction

    task check_drained();
      if (expected_counts.size() != 0)
        report($sformatf("%0d results never arrived", expected_counts.size()));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  bpp_pix_if pix ();
  bpp_res_if res ();
  bpp_cfg_if cfg ();

  black_pixel_projection_profile_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix),
    .res_o  (res),
    .cfg_i  (cfg)
  );

  profile_scoreboard sb;
  int unsigned       src_idle_pct = 8;
  int unsigned       snk_idle_pct = 87;
  int unsigned       items_sent   = 0;
  bit                hold_go      = 1'b0;
  bit                rx_hold      = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_400_000;
    $display("TB_ERROR");
    $finish;
  end

  // long receiver hold-off, counted here so the sender keeps pushing meanwhile
  initial begin : rx_hold_counter
    wait (hold_go);
    @(negedge clk_i);
    rx_hold = 1'b1;
    repeat (400) @(negedge clk_i);
    rx_hold = 1'b0;
  end

  initial begin : result_sink
    result_t seen;
    bit      fired;
    fired = 1'b0;
    res.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      fired              = (res.valid === 1'b1) && (res.ready === 1'b1);
      seen.profile_kind  = res.profile_kind;
      seen.profile_index = res.profile_index;
      seen.black_count   = res.black_count;
      @(posedge clk_i);
      if (fired) sb.compare_count(seen);
      res.ready <= !rx_hold && ($urandom_range(99) >= snk_idle_pct);
    end
  end

  task automatic send_item(opcode_e op, logic [PIXEL_W-1:0] value,
                           logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
    bit took;
    while ($urandom_range(99) < src_idle_pct) begin
      pix.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix.valid        <= 1'b1;
    pix.opcode       <= op;
    pix.pixel_value  <= value;
    pix.pixel_column <= col;
    pix.pixel_row    <= row;
    do begin
      @(negedge clk_i);
      took = (pix.ready === 1'b1);
      @(posedge clk_i);
    end while (!took);
    items_sent++;
    sb.predict_profile(op, value, col, row);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [COUNT_W-1:0] data);
    bit took;
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do begin
      @(negedge clk_i);
      took = (cfg.ready === 1'b1);
      @(posedge clk_i);
    end while (!took);
    sb.set_register(idx, data);
    cfg.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait for every expected count, then for any pixel still in flight.
  task automatic settle();
    pix.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  function automatic logic [PIXEL_W-1:0] pixel_byte();
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll < 5) return '0;
    if (roll == 5) return 8'hFF;
    return PIXEL_W'($urandom_range(1, 255));
  endfunction

  task automatic stray_item();
    if ($urandom_range(1))
      send_item(OP_READOUT, PIXEL_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
    else
      send_item(OP_PIXEL, pixel_byte(), COORD_W'($urandom), COORD_W'($urandom));
  endtask

  // One raster row from just left of the region to just right of it, with
  // occasional dropped, repeated and stray transactions.
  task automatic raster_row(int unsigned first_c, int unsigned last_c,
                            logic [COORD_W-1:0] row);
    int unsigned c, lo, hi, roll;
    lo = (first_c > 0) ? first_c - 1 : first_c;
    hi = (last_c < IMAGE_LAST_COLUMN) ? last_c + 1 : last_c;
    for (c = lo; c <= hi; c++) begin
      roll = $urandom_range(99);
      if (roll < 4) continue;
      if (roll >= 88) stray_item();
      if (roll < 7) send_item(OP_PIXEL, pixel_byte(), COORD_W'(c), row);
      send_item(OP_PIXEL, pixel_byte(), COORD_W'(c), row);
    end
  endtask

  task automatic region_phase();
    logic [COUNT_W-1:0] left_d, top_d, width_d, height_d;
    int unsigned        left, top, w_eff, span, last_c, nrows, r;
    left_d   = COUNT_W'($urandom);
    top_d    = COUNT_W'($urandom);
    width_d  = COUNT_W'($urandom_range(1, 24));
    height_d = COUNT_W'($urandom_range(1, 6));
    case ($urandom_range(11))
      0: begin
        if ($urandom_range(1)) width_d = '0;
        else height_d = '0;
      end
      1, 2: begin
        left_d[COORD_W-1:0] = COORD_W'(IMAGE_LAST_COLUMN - $urandom_range(30));
        case ($urandom_range(3))
          0: width_d = REGION_DIM_RESET;
          1: width_d = '1;
          default: width_d = COUNT_W'($urandom_range(31, 8191));
        endcase
      end
      3: begin
        left_d[COORD_W-1:0] = '0;
        top_d[COORD_W-1:0]  = $urandom_range(1) ? '0 : IMAGE_LAST_COLUMN;
        height_d            = $urandom_range(1) ? REGION_DIM_RESET : '1;
      end
      4: top_d[COORD_W-1:0] = COORD_W'(IMAGE_LAST_COLUMN - $urandom_range(3));
      default: ;
    endcase
    write_reg(REG_LEFT, left_d);
    write_reg(REG_TOP, top_d);
    write_reg(REG_WIDTH, width_d);
    write_reg(REG_HEIGHT, height_d);

    left   = left_d[COORD_W-1:0];
    top    = top_d[COORD_W-1:0];
    w_eff  = (width_d > MAX_REGION_WIDTH) ? MAX_REGION_WIDTH : width_d;
    span   = (w_eff == 0) ? 8 : w_eff;
    last_c = left + span - 1;
    if (last_c > IMAGE_LAST_COLUMN) last_c = IMAGE_LAST_COLUMN;
    nrows  = $urandom_range(1, 5);
    for (r = 0; r < nrows; r++) raster_row(left, last_c, COORD_W'(top + r));

    for (r = 0; r <= last_c - left; r++)
      send_item(OP_READOUT, PIXEL_W'($urandom), COORD_W'(r), COORD_W'($urandom));
    if ($urandom_range(3) == 0) stray_item();
  endtask

  task automatic random_stream(int unsigned budget);
    int unsigned stop_at;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      region_phase();
      settle();
    end
  endtask

  task automatic directed_items();
    // power-up region is the whole image
    send_item(OP_PIXEL, 8'd0, 12'd0, 12'd0);
    send_item(OP_PIXEL, 8'hFF, 12'd4095, 12'd0);
    send_item(OP_READOUT, 8'd0, 12'd0, 12'hFFF);
    send_item(OP_READOUT, 8'hFF, 12'd4095, 12'd0);
    settle();

    // oversized width clipped at the image edge; bit 12 of left is dropped
    write_reg(REG_LEFT, 13'h1FA0);
    write_reg(REG_TOP, 13'd4090);
    write_reg(REG_WIDTH, 13'h1FFF);
    write_reg(REG_HEIGHT, 13'd6);
    send_item(OP_PIXEL, 8'd0, 12'd3999, 12'd4090);
    send_item(OP_PIXEL, 8'd0, 12'd4000, 12'd4089);
    send_item(OP_PIXEL, 8'd0, 12'd4000, 12'd4095);
    send_item(OP_PIXEL, 8'd0, 12'd4095, 12'd4095);
    send_item(OP_PIXEL, 8'd1, 12'd4095, 12'd4090);
    send_item(OP_READOUT, 8'd0, 12'd0, 12'd0);
    send_item(OP_READOUT, 8'd0, 12'd95, 12'd0);
    settle();

    // empty region: zero width, then zero height
    write_reg(REG_WIDTH, 13'd0);
    send_item(OP_PIXEL, 8'd0, 12'd4000, 12'd4090);
    send_item(OP_PIXEL, 8'd0, 12'd4095, 12'd4090);
    settle();
    write_reg(REG_WIDTH, 13'd1);
    write_reg(REG_HEIGHT, 13'd0);
    send_item(OP_PIXEL, 8'd0, 12'd4000, 12'd4090);
    settle();

    // last pixel of row 0 missing: its count carries into row 1
    write_reg(REG_LEFT, 13'd0);
    write_reg(REG_TOP, 13'd0);
    write_reg(REG_WIDTH, 13'd4);
    write_reg(REG_HEIGHT, 13'd4096);
    send_item(OP_PIXEL, 8'd0, 12'd0, 12'd0);
    send_item(OP_PIXEL, 8'd0, 12'd1, 12'd0);
    send_item(OP_PIXEL, 8'd0, 12'd0, 12'd1);
    send_item(OP_PIXEL, 8'h80, 12'd3, 12'd1);
    send_item(OP_READOUT, 8'd0, 12'd0, 12'd0);
    send_item(OP_READOUT, 8'd0, 12'd1, 12'd0);
    settle();
  endtask

  // Same black pixel over and over, back to back into one column entry.
  task automatic repeated_pixels();
    write_reg(REG_LEFT, 13'd0);
    write_reg(REG_TOP, 13'd0);
    write_reg(REG_WIDTH, REGION_DIM_RESET);
    write_reg(REG_HEIGHT, REGION_DIM_RESET);
    repeat (60) send_item(OP_PIXEL, 8'd0, 12'd7, 12'd100);
    send_item(OP_PIXEL, 8'd0, 12'd4095, 12'd100);
    send_item(OP_READOUT, 8'd0, 12'd7, 12'd0);
    send_item(OP_READOUT, 8'd0, 12'd4095, 12'd0);
    settle();
  endtask

  initial begin : stimulus
    sb = new();
    rst_ni           <= 1'b0;
    pix.valid        <= 1'b0;
    pix.opcode       <= OP_PIXEL;
    pix.pixel_value  <= '0;
    pix.pixel_column <= '0;
    pix.pixel_row    <= '0;
    cfg.valid        <= 1'b0;
    cfg.index        <= REG_LEFT;
    cfg.data         <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_items();
    random_stream(600);

    src_idle_pct = 87;
    snk_idle_pct = 8;
    random_stream(600);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_go = 1'b1;
    repeat (48)
      send_item(OP_READOUT, PIXEL_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
    settle();
    repeated_pixels();
    random_stream(600);

    settle();
    repeat (20) @(posedge clk_i);
    sb.check_drained();
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
